// ===== rtl/core/slda_pkg.sv =====
// Shared types and constants for the sensor link deframer and averager.
// Holds the queued job layout, channel codes and the emission slot order.
// No dependencies; slda_front, slda_back and the top level import this package.
package slda_pkg;

  // Emission slots, in the order results leave for one data byte.
  localparam int NUM_SLOTS = 7;
  localparam int S_SKIN1   = 0;
  localparam int S_ORAL    = 1;
  localparam int S_RESP    = 2;
  localparam int S_WAVE    = 3;
  localparam int S_PRESP   = 4;
  localparam int S_PWAVE   = 5;
  localparam int S_SKIN2   = 6;

  // Channel codes as they appear in header bits 6..3 and on the result.
  localparam logic [3:0] CH_SKIN1 = 4'd0;
  localparam logic [3:0] CH_ORAL  = 4'd1;
  localparam logic [3:0] CH_SKIN2 = 4'd2;
  localparam logic [3:0] CH_WAVE  = 4'd5;
  localparam logic [3:0] CH_RESP  = 4'd6;
  localparam logic [3:0] CH_PWAVE = 4'd9;
  localparam logic [3:0] CH_PRESP = 4'd12;

  localparam logic [3:0] SLOT_CHANNEL [NUM_SLOTS] = '{
    CH_SKIN1, CH_ORAL, CH_RESP, CH_WAVE, CH_PRESP, CH_PWAVE, CH_SKIN2
  };

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_SKIN_BLOCK = 2'd0;
  localparam logic [1:0] CFG_RANGE_LOW  = 2'd1;
  localparam logic [1:0] CFG_RANGE_HIGH = 2'd2;
  localparam logic [9:0] RANGE_LOW_RST  = 10'd200;
  localparam logic [9:0] RANGE_HIGH_RST = 10'd700;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic       skin_block;
    logic [9:0] range_low;
    logic [9:0] range_high;
  } cfg_t;

  // One data byte's work: which channels to report and the assembled values.
  typedef struct packed {
    slot_mask_t mask;
    logic [9:0] full;
    logic [6:0] data;
  } job_t;

  function automatic slot_mask_t code_to_mask(input logic [3:0] code);
    slot_mask_t m;
    m = '0;
    unique case (code)
      CH_SKIN1: m[S_SKIN1] = 1'b1;
      CH_ORAL:  m[S_ORAL]  = 1'b1;
      CH_SKIN2: m[S_SKIN2] = 1'b1;
      CH_WAVE:  m[S_WAVE]  = 1'b1;
      CH_RESP:  m[S_RESP]  = 1'b1;
      CH_PWAVE: m[S_PWAVE] = 1'b1;
      CH_PRESP: m[S_PRESP] = 1'b1;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/slda_byte_if.sv =====
// Valid/ready channel that carries one link byte per transaction.
// No dependencies.
interface slda_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/slda_result_if.sv =====
// Valid/ready channel that carries one channel result per transaction.
// No dependencies.
interface slda_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel;
  logic [9:0] value;
  logic       in_range;
  logic       last;

  modport source (output valid, output channel, output value, output in_range,
                  output last, input ready);
  modport sink   (input valid, input channel, input value, input in_range,
                  input last, output ready);
endinterface

// ===== rtl/core/slda_queue.sv =====
// Small flip-flop FIFO between the deframer and the result sequencer.
// Generic width and depth; no package dependency.
module slda_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== rtl/core/slda_front.sv =====
// Deframer, using slda_pkg and slda_byte_if: takes link bytes, tracks header bits
// and pending channels, and queues each data byte after a header with channels due.
module slda_front import slda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  slda_byte_if.sink   rx,
  output logic        push,
  output job_t        job,
  input  logic        q_full
);
  logic [2:0] header_bits;
  logic       header_seen;
  slot_mask_t pending;
  slot_mask_t skin_hold;
  slot_mask_t emit_mask;
  logic       accept;
  logic       is_header;

  assign rx.ready  = !q_full;
  assign accept    = rx.valid && rx.ready;
  assign is_header = rx.rx_byte[7];

  always_comb begin
    skin_hold = '0;
    if (cfg.skin_block) begin
      skin_hold[S_SKIN1] = 1'b1;
      skin_hold[S_SKIN2] = 1'b1;
    end
    emit_mask = pending & ~skin_hold;
    job.mask  = emit_mask;
    // Data bytes have bit 7 clear, so the weighted header bits simply sit above them.
    job.full  = {header_bits[1], header_bits[0], header_bits[2], rx.rx_byte[6:0]};
    job.data  = rx.rx_byte[6:0];
    push      = accept && !is_header && header_seen && (emit_mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bits <= '0;
      header_seen <= 1'b0;
      pending     <= '0;
    end else if (accept) begin
      if (is_header) begin
        header_bits <= rx.rx_byte[2:0];
        header_seen <= 1'b1;
        pending     <= pending | code_to_mask(rx.rx_byte[6:3]);
      end else if (header_seen) begin
        header_seen <= 1'b0;
        pending     <= pending & ~emit_mask;
      end
    end
  end
endmodule

// ===== rtl/core/slda_back.sv =====
// Result sequencer: pops jobs, runs the skin1 block average and emits one
// result per cycle, unless the receiver stalls, into the output register. Uses slda_pkg and slda_result_if.
module slda_back import slda_pkg::*; #(
  parameter int AVG_SAMPLES = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_empty,
  input  job_t          q_head,
  output logic          pop,
  slda_result_if.source result
);
  localparam int DIVISOR   = AVG_SAMPLES + 1;
  localparam int DIV_SHIFT = 20;
  localparam int RECIP     = (1 << DIV_SHIFT) / DIVISOR;
  localparam int DIVD_W    = 15;
  localparam int PROD_W    = DIVD_W + DIV_SHIFT;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t      state;
  job_t        cur;
  logic [13:0] avg_sum;
  logic [3:0]  avg_count;
  logic [9:0]  avg_value;
  logic [DIVD_W-1:0] dividend;
  logic [PROD_W-1:0] prod;

  logic [13:0] sum_next;
  logic [3:0]  count_next;
  logic [DIVD_W-1:0] quot_est;
  logic [DIVD_W+4:0] remainder;
  logic [2:0]  sel;
  slot_mask_t  remaining;
  logic [9:0]  sel_value;
  logic        slot_free;

  assign slot_free  = !result.valid || result.ready;
  assign pop        = (state == ST_IDLE) && !q_empty;
  assign sum_next   = avg_sum + 14'(cur.full);
  assign count_next = avg_count + 1'b1;
  assign quot_est   = prod[DIV_SHIFT +: DIVD_W];
  assign remainder  = (DIVD_W+5)'(dividend) - (DIVD_W+5)'(quot_est) * (DIVD_W+5)'(DIVISOR);

  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        sel = 3'(i);
      end
    end
    remaining      = cur.mask;
    remaining[sel] = 1'b0;
    priority if (sel == 3'(S_SKIN1)) begin
      sel_value = avg_value;
    end else if (sel == 3'(S_RESP) || sel == 3'(S_PRESP)) begin
      sel_value = {3'b000, cur.data};
    end else begin
      sel_value = cur.full;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cur <= q_head;
    end else if (state == ST_EMIT && slot_free) begin
      cur.mask <= remaining;
    end
    if (state == ST_SUM) begin
      dividend <= DIVD_W'(avg_value) + DIVD_W'(sum_next);
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(dividend) * PROD_W'(RECIP);
    end
    if (state == ST_EMIT && slot_free) begin
      result.channel  <= SLOT_CHANNEL[sel];
      result.value    <= sel_value;
      result.in_range <= (sel_value > cfg.range_low) && (sel_value < cfg.range_high);
      result.last     <= (remaining == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      avg_sum      <= '0;
      avg_count    <= '0;
      avg_value    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && slot_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= q_head.mask[S_SKIN1] ? ST_SUM : ST_EMIT;
          end
        end
        ST_SUM: begin
          if (count_next >= 4'(AVG_SAMPLES)) begin
            avg_sum   <= '0;
            avg_count <= '0;
            state     <= ST_MUL;
          end else begin
            avg_sum   <= sum_next;
            avg_count <= count_next;
            state     <= ST_EMIT;
          end
        end
        ST_MUL: begin
          state <= ST_FIX;
        end
        ST_FIX: begin
          // The reciprocal estimate is at most one below the true quotient.
          if (remainder >= (DIVD_W+5)'(DIVISOR)) begin
            avg_value <= 10'(quot_est + 1'b1);
          end else begin
            avg_value <= 10'(quot_est);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free && remaining == '0) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/sensor_link_deframer_averager_core.sv =====
// Top level of the sensor link deframer and averager.
// Depends on slda_pkg, slda_byte_if, slda_result_if, slda_queue, slda_front
// and slda_back.
//
// Usage: link bytes enter on rx, one per transaction. A byte with bit 7 set is
// a header that marks its channel pending; the next byte with bit 7 clear is
// data and yields one result per pending channel on result, in the order
// skin1, oral, resp, wave, presp, pwave, skin2, with last set on the final one.
// skin_block holds back skin1 and skin2. Registers are written through
// cfg_wr_en/cfg_index/cfg_data, only while idle; the user must keep to this,
// the block does not enforce it. Throughput: the deframer takes a byte every
// cycle while its job queue has room. The sequencer loads each job, then emits
// its results one per cycle while the receiver takes them; a reported skin1
// adds a summing step, and a sample that completes an average block adds the
// reciprocal multiply and the correction. A stalled result receiver holds the
// output register; jobs then gather in the queue and rx.ready drops when it
// fills. Reset clears the pending set, the averager and the output, and loads
// the range bounds with 200 and 700 and skin_block with zero.
module sensor_link_deframer_averager_core import slda_pkg::*; #(
  parameter int AVG_SAMPLES = 9,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  slda_byte_if.sink     rx,
  slda_result_if.source result,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [9:0]    cfg_data
);
  cfg_t cfg;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_empty;
  logic pop;
  job_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skin_block <= 1'b0;
      cfg.range_low  <= RANGE_LOW_RST;
      cfg.range_high <= RANGE_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SKIN_BLOCK: cfg.skin_block <= cfg_data[0];
        CFG_RANGE_LOW:  cfg.range_low  <= cfg_data;
        CFG_RANGE_HIGH: cfg.range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  slda_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .rx     (rx),
    .push   (push),
    .job    (push_job),
    .q_full (q_full)
  );

  slda_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  slda_back #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .result  (result)
  );
endmodule
